FILE: hdl/brbo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbo_pkg: shared types for the byte FIFO with overwrite
// Operation codes, the per-cell control word and the result record.
// ----------------------------------------------------------------------------
package brbo_pkg;

  localparam int BYTE_W = 8;
  localparam int FILL_W = 5;

  typedef enum logic {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } op_t;

  // Control word for one storage cell
  typedef struct packed {
    logic shift;  // take the byte of the neighbour further from the head
    logic load;   // take the incoming byte
  } cell_ctl_t;

  // One result record
  typedef struct packed {
    logic              success;
    logic [BYTE_W-1:0] data_out;
    logic              dropped_oldest;
    logic [FILL_W-1:0] fill_level;
  } res_t;

endpackage

FILE: hdl/brbo_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbo_cell: one byte cell of the storage chain
// Holds one byte; loads a new byte, takes its neighbour's byte, or holds.
// ----------------------------------------------------------------------------
module brbo_cell
  import brbo_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [BYTE_W-1:0] load_data,
  input  logic [BYTE_W-1:0] nbr_data,
  output logic [BYTE_W-1:0] data
);

  logic [BYTE_W-1:0] data_r;
  logic [BYTE_W-1:0] data_nxt;

  // Load wins over shift: the tail cell does both when the oldest is dropped
  always_comb begin
    priority if (ctl.load) begin
      data_nxt = load_data;
    end else if (ctl.shift) begin
      data_nxt = nbr_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

FILE: hdl/brbo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbo_ctrl: fill counter and chain control
// Tracks the byte count, decides each request and steers the cell chain.
// ----------------------------------------------------------------------------
module brbo_ctrl
  import brbo_pkg::*;
#(
  parameter int DEPTH = 16
)(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  op_t               op,
  input  logic              overwrite,
  input  logic [BYTE_W-1:0] head_data,
  output logic              shift,
  output logic [DEPTH-1:0]  load,
  output res_t              res
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(DEPTH - 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] count_after;
  logic [CNT_W-1:0] load_pos;
  logic             full;
  logic             empty;
  logic             do_put;
  logic             do_get;
  logic             drop;

  // Decide the request against the current count
  always_comb begin
    full   = (count_r == FULL_CNT);
    empty  = (count_r == '0);
    do_put = (op == OP_PUT) && (!full || overwrite);
    drop   = (op == OP_PUT) && full && overwrite;
    do_get = (op == OP_GET) && !empty;
  end

  // Count after the request; a drop keeps the buffer full
  always_comb begin
    priority if (do_put && !full) begin
      count_after = count_r + CNT_W'(1);
    end else if (do_get) begin
      count_after = count_r - CNT_W'(1);
    end else begin
      count_after = count_r;
    end
  end

  assign count_nxt = accept ? count_after : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Steer the chain: advance towards the head on a get or a drop
  assign shift    = accept && (do_get || drop);
  assign load_pos = drop ? LAST_POS : count_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_load
    assign load[i] = accept && do_put && (load_pos == CNT_W'(i));
  end

  // Build the result record
  always_comb begin
    res.success        = do_put || do_get;
    res.data_out       = do_get ? head_data : '0;
    res.dropped_oldest = drop;
    res.fill_level     = FILL_W'(count_after);
  end

endmodule

FILE: hdl/byte_ring_buffer_overwrite.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_overwrite: byte FIFO with optional overwrite of the oldest
// Each request on the input channel is a put or a get. Every request gives
// one result on the output channel: success, the byte got (zero otherwise),
// whether the oldest byte was dropped, and the fill level afterwards.
// The bytes sit in a chain of DEPTH cells, the oldest at the head cell; a
// get or a drop moves every byte one cell towards the head.
// The result is registered at the edge that takes the request. One request
// is taken each cycle while the output is free or being taken, so throughput
// is one request per cycle, set by the output register.
// When the receiver stalls with a result waiting, in_stall rises until it is
// taken; results are never lost or repeated.
// The configuration channel writes overwrite_when_full (reset 0) and is always
// ready. Write it only while the block is idle; the block does not enforce it.
// Synchronous reset empties the FIFO and clears the output valid flag; the
// cell contents are not cleared, as no get can reach an unwritten cell.
// ----------------------------------------------------------------------------
module byte_ring_buffer_overwrite
  import brbo_pkg::*;
#(
  parameter int DEPTH = 16
)(
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [BYTE_W-1:0] in_data_in,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_success,
  output logic [BYTE_W-1:0] out_data_out,
  output logic              out_dropped_oldest,
  output logic [FILL_W-1:0] out_fill_level,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_overwrite_when_full
);

  logic              overwrite_r;
  logic              overwrite_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  res_t              res_r;
  res_t              res_nxt;
  res_t              res;
  logic              accept;
  logic              shift;
  logic [DEPTH-1:0]  load;
  logic [BYTE_W-1:0] cell_data [DEPTH];

  // Configuration register
  assign cfg_ready     = 1'b1;
  assign overwrite_nxt = (cfg_valid && cfg_ready) ? cfg_overwrite_when_full : overwrite_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overwrite_r <= 1'b0;
    end else begin
      overwrite_r <= overwrite_nxt;
    end
  end

  // Take a request while the output register is free or being emptied
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  brbo_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .op        (op_t'(in_operation)),
    .overwrite (overwrite_r),
    .head_data (cell_data[0]),
    .shift     (shift),
    .load      (load),
    .res       (res)
  );

  // Cell chain; the head cell holds the oldest byte
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t         ctl;
    logic [BYTE_W-1:0] nbr;

    assign ctl.shift = shift;
    assign ctl.load  = load[i];

    if (i == DEPTH - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_body
      assign nbr = cell_data[i+1];
    end

    brbo_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_data (in_data_in),
      .nbr_data  (nbr),
      .data      (cell_data[i])
    );
  end

  // Output register: hold while stalled, load on each request
  always_comb begin
    priority if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  assign res_nxt = accept ? res : res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_success        = res_r.success;
  assign out_data_out       = res_r.data_out;
  assign out_dropped_oldest = res_r.dropped_oldest;
  assign out_fill_level     = res_r.fill_level;

endmodule

FILE: dv/byte_ring_buffer_overwrite_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_overwrite_tb: self-checking bench for the overwrite FIFO
// A queue of put/get requests feeds a clocked driver, and the bench keeps its
// own copy of the ring to predict each result. A clocked monitor compares
// every result taken with the oldest prediction. Directed requests cover an
// empty get, filling, a refused put, overwrite of the oldest byte and
// draining. Random phases, with the overwrite mode set anew before each, then
// swing the fill level between empty and full, under random stalls on both
// channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module byte_ring_buffer_overwrite_tb
  import brbo_pkg::*;
();

  localparam int DEPTH       = 16;
  localparam int SLOTS       = DEPTH + 1;
  localparam int PHASE_LEN   = 125;
  localparam int HOLD_AT     = 180;
  localparam int HOLD_CYCLES = 90;

  typedef struct {
    op_t               op;
    logic [BYTE_W-1:0] data;
  } fifo_request_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_operation = OP_PUT;
  logic [BYTE_W-1:0] in_data_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_success;
  logic [BYTE_W-1:0] out_data_out;
  logic              out_dropped_oldest;
  logic [FILL_W-1:0] out_fill_level;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_overwrite_when_full = 1'b0;

  // Bench copy of the ring and its indices
  logic [BYTE_W-1:0] ring_bytes [SLOTS];
  logic [4:0]        wr_slot = '0;
  logic [4:0]        rd_slot = '0;
  logic              overwrite_mode = 1'b0;

  fifo_request_t requests_pending [$];
  res_t          fifo_results_due [$];
  fifo_request_t next_req;
  int            requests_queued = 0;
  int            requests_taken = 0;
  int            mismatch_count = 0;
  int            gap_left = 0;
  int            stall_left = 0;
  int            hold_left = 0;
  logic          hold_done = 1'b0;
  logic          quiet_tail = 1'b0;

  byte_ring_buffer_overwrite #(.DEPTH(DEPTH)) uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_operation            (in_operation),
    .in_data_in              (in_data_in),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_success             (out_success),
    .out_data_out            (out_data_out),
    .out_dropped_oldest      (out_dropped_oldest),
    .out_fill_level          (out_fill_level),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_overwrite_when_full (cfg_overwrite_when_full)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("byte_ring_buffer_overwrite_tb: FAIL");
    $finish;
  end

  function automatic logic [4:0] next_slot(input logic [4:0] s);
    return (s == 5'(SLOTS - 1)) ? 5'd0 : s + 5'd1;
  endfunction

  // Advance the bench ring by one request and record the result it must give
  task automatic predict_fifo_result(input op_t op, input logic [BYTE_W-1:0] byte_in);
    res_t       r;
    logic [4:0] nxt;
    int         level;
    r = '0;
    if (op == OP_PUT) begin
      nxt = next_slot(wr_slot);
      if (nxt != rd_slot || overwrite_mode) begin
        if (nxt == rd_slot) begin
          rd_slot = next_slot(rd_slot);
          r.dropped_oldest = 1'b1;
        end
        ring_bytes[wr_slot] = byte_in;
        wr_slot = nxt;
        r.success = 1'b1;
      end
    end else if (wr_slot != rd_slot) begin
      r.data_out = ring_bytes[rd_slot];
      rd_slot = next_slot(rd_slot);
      r.success = 1'b1;
    end
    level = (int'(wr_slot) + SLOTS - int'(rd_slot)) % SLOTS;
    r.fill_level = FILL_W'(level);
    fifo_results_due.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_request(input op_t op, input logic [BYTE_W-1:0] b);
    fifo_request_t req;
    req.op = op;
    req.data = b;
    requests_pending.push_back(req);
    requests_queued++;
  endtask

  // Fill the queue with put-heavy, get-heavy or even bursts so the level swings
  task automatic queue_random_phase(input int count);
    int put_pct;
    int run;
    while (count > 0) begin
      case ($urandom_range(0, 2))
        0:       put_pct = 85;
        1:       put_pct = 15;
        default: put_pct = 50;
      endcase
      run = $urandom_range(4, 24);
      while (run > 0 && count > 0) begin
        queue_request(($urandom_range(0, 99) < put_pct) ? OP_PUT : OP_GET,
                      8'($urandom_range(0, 255)));
        run--;
        count--;
      end
    end
  endtask

  // Wait until every request has been taken and every result has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (requests_taken != requests_queued || fifo_results_due.size() != 0);
  endtask

  task automatic write_overwrite(input logic value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_overwrite_when_full <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Track the overwrite mode as the block takes it
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      overwrite_mode <= cfg_overwrite_when_full;
    end
  end

  // Driver: offer queued requests, hold while stalled, idle in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_fifo_result(op_t'(in_operation), in_data_in);
        requests_taken++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (requests_pending.size() != 0 && !quiet_tail
                   && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 13);
      end else if (requests_pending.size() != 0) begin
        next_req = requests_pending.pop_front();
        in_valid <= 1'b1;
        in_operation <= next_req.op;
        in_data_in <= next_req.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off, otherwise random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && requests_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each result taken with the oldest prediction
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (fifo_results_due.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = fifo_results_due.pop_front();
        if (out_success !== want.success)
          report_mismatch("success", out_success, want.success);
        if (out_data_out !== want.data_out)
          report_mismatch("data_out", out_data_out, want.data_out);
        if (out_dropped_oldest !== want.dropped_oldest)
          report_mismatch("dropped_oldest", out_dropped_oldest, want.dropped_oldest);
        if (out_fill_level !== want.fill_level)
          report_mismatch("fill_level", out_fill_level, want.fill_level);
      end
    end
  end

  initial begin : stimulus
    bit [5:0] phase_overwrite;
    phase_overwrite = 6'b010110;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Refusing mode: get from empty, fill to the top, then one put too many
    write_overwrite(1'b0);
    queue_request(OP_GET, 8'hFF);
    queue_request(OP_PUT, 8'h00);
    queue_request(OP_PUT, 8'hFF);
    for (int i = 2; i < DEPTH + 1; i++) begin
      queue_request(OP_PUT, 8'(i * 8'h3B));
    end
    wait_idle();

    // Overwrite mode: drop the oldest twice, then drain a few
    write_overwrite(1'b1);
    queue_request(OP_PUT, 8'h5A);
    queue_request(OP_PUT, 8'hC3);
    repeat (3) queue_request(OP_GET, 8'h00);
    wait_idle();

    // Random phases, setting the mode before each; no idling in the last
    for (int p = 0; p < 6; p++) begin
      write_overwrite(phase_overwrite[p]);
      if (p == 5) begin
        @(posedge clk);
        quiet_tail <= 1'b1;
      end
      queue_random_phase(PHASE_LEN);
      wait_idle();
    end

    repeat (5) @(posedge clk);
    if (fifo_results_due.size() != 0) begin
      report_mismatch("results outstanding", fifo_results_due.size(), 0);
    end
    if (mismatch_count == 0) begin
      $display("byte_ring_buffer_overwrite_tb: PASS");
    end else begin
      $display("byte_ring_buffer_overwrite_tb: FAIL");
    end
    $finish;
  end

endmodule
